>>> rtl/core/cal_pkg.sv
// Shared types and constants for the compacting array list.
package cal_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned AMOUNT_W   = 16;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned COST_W     = 32;
    localparam int unsigned CAP_W      = 5;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_TDATA_W  = 72;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Largest index the request format can address, plus one.
    localparam int unsigned INDEX_SPAN = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_READ     = 2'd2,
        OP_ADD_COST = 2'd3
    } op_t;

    // Per-cycle control broadcast along the row of cells.
    typedef struct packed {
        logic               append;
        logic               remove;
        logic [INDEX_W-1:0] index;
    } cell_ctrl_t;

endpackage

>>> rtl/core/cal_cell.sv
// One storage cell of the list: holds an entry, loads on append, shifts down on remove.
module cal_cell #(
    parameter int unsigned CELL_IDX   = 0,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CNT_W      = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cal_pkg::cell_ctrl_t     ctrl,
    input  logic [CNT_W-1:0]        count,
    input  logic [DATA_WIDTH-1:0]   append_data,
    input  logic [DATA_WIDTH-1:0]   upper_data,
    output logic [DATA_WIDTH-1:0]   data
);

    localparam logic [CNT_W-1:0] POS = CNT_W'(CELL_IDX);
    localparam int unsigned IDX_CLAMP =
        (CELL_IDX >= cal_pkg::INDEX_SPAN) ? cal_pkg::INDEX_SPAN - 1 : CELL_IDX;
    localparam logic ABOVE_SPAN = (CELL_IDX >= cal_pkg::INDEX_SPAN);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  shift_en;
    logic                  load_en;

    // Slots at or above the length always hold zero, so a plain shift of every
    // cell from the removed index upward also clears the freed slot.
    assign shift_en = ctrl.remove &&
        (ABOVE_SPAN || (cal_pkg::INDEX_W'(IDX_CLAMP) >= ctrl.index));
    assign load_en  = ctrl.append && (count == POS);

    always_comb begin
        data_next = data_reg;
        if (shift_en) begin
            data_next = upper_data;
        end else if (load_en) begin
            data_next = append_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

>>> rtl/core/compacting_array_list_unit.sv
// Top level of the compacting array list: request decode, cell row, counters and result register.
// A request accepted at one clock edge has its result valid after that edge.
// Throughput: one request per cycle while results are taken; every request updates the row of
// cells, the length and the cost counter, and the next request sees that state at once.
// The result register refills in the same cycle it is emptied, so a stalled result only
// holds off new requests while it is not being taken.
// Reset (aresetn low, synchronous): the list empties, all entries and the cost counter go to
// zero, the capacity returns to 16 and no result is pending.
module compacting_array_list_unit #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Capacity register write.
    input  logic                            cfg_wr_en,
    input  logic [cal_pkg::CAP_W-1:0]       cfg_wr_data,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: value[31:0], index[35:32], amount[51:36], zero fill[55:52].
    input  logic [cal_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: operation[1:0].
    input  logic [cal_pkg::OP_W-1:0]        s_tuser,
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: read_value[31:0], length[36:32], cost_count[68:37], zero fill[71:69].
    output logic [cal_pkg::M_TDATA_W-1:0]   m_tdata,
    // Fields from bit 0: error[0].
    output logic                            m_tuser
);

    // The length counter has to hold DEPTH itself; comparisons against the 5-bit
    // capacity and the 4-bit index are done at the wider of the counter and capacity widths.
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CMP_W = (CNT_W > cal_pkg::LEN_W) ? CNT_W : cal_pkg::LEN_W;
    localparam int unsigned RD_N  =
        (DEPTH < cal_pkg::INDEX_SPAN) ? DEPTH : cal_pkg::INDEX_SPAN;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Request fields.
    cal_pkg::op_t                   req_op;
    logic [cal_pkg::VALUE_W-1:0]    req_value;
    logic [cal_pkg::INDEX_W-1:0]    req_index;
    logic [cal_pkg::AMOUNT_W-1:0]   req_amount;
    logic                           req_fire;

    assign req_op     = cal_pkg::op_t'(s_tuser);
    assign req_value  = s_tdata[31:0];
    assign req_index  = s_tdata[35:32];
    assign req_amount = s_tdata[51:36];

    // State.
    logic [cal_pkg::CAP_W-1:0]      capacity_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [cal_pkg::COST_W-1:0]     cost_reg;
    logic [cal_pkg::COST_W-1:0]     cost_next;

    // Result register.
    logic                           m_valid_reg;
    logic [cal_pkg::M_TDATA_W-1:0]  m_data_reg;
    logic [cal_pkg::M_TDATA_W-1:0]  m_data_next;
    logic                           m_err_reg;

    // Decode.
    logic [CMP_W-1:0]               count_ext;
    logic [CMP_W-1:0]               next_ext;
    logic [CMP_W-1:0]               cap_ext;
    logic [CMP_W-1:0]               index_ext;
    logic                           list_full;
    logic                           index_ok;
    logic                           remove_last;
    logic                           err;
    cal_pkg::cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0]          append_data;
    logic [cal_pkg::VALUE_W-1:0]    read_data;

    logic [DATA_WIDTH-1:0]          cell_data [DEPTH];

    // A new request is taken whenever the result register is empty or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign req_fire = s_tvalid && s_tready;

    assign count_ext = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(capacity_reg);
    assign index_ext = CMP_W'(req_index);

    // A capacity above the built depth is limited to the depth; zero means always full.
    assign list_full   = (count_ext >= cap_ext) || (count_reg == DEPTH_CNT);
    assign index_ok    = index_ext < count_ext;
    assign remove_last = (index_ext + CMP_W'(1)) == count_ext;

    always_comb begin
        ctrl.append = 1'b0;
        ctrl.remove = 1'b0;
        ctrl.index  = req_index;
        err         = 1'b0;
        count_next  = count_reg;
        cost_next   = cost_reg;
        unique case (req_op)
            cal_pkg::OP_APPEND: begin
                if (list_full) begin
                    err = 1'b1;
                end else begin
                    ctrl.append = req_fire;
                    count_next  = count_reg + CNT_W'(1);
                    cost_next   = cost_reg + cal_pkg::COST_W'(1);
                end
            end
            cal_pkg::OP_REMOVE: begin
                if (!index_ok) begin
                    err = 1'b1;
                end else begin
                    ctrl.remove = req_fire;
                    count_next  = count_reg - CNT_W'(1);
                    // Removing the last entry costs one; any earlier entry costs the
                    // number of moves after it, less one.
                    if (remove_last) begin
                        cost_next = cost_reg + cal_pkg::COST_W'(1);
                    end else begin
                        cost_next = cost_reg + cal_pkg::COST_W'(count_reg)
                                  - cal_pkg::COST_W'(2) - cal_pkg::COST_W'(req_index);
                    end
                end
            end
            cal_pkg::OP_READ: begin
                err = !index_ok;
            end
            cal_pkg::OP_ADD_COST: begin
                cost_next = cost_reg + cal_pkg::COST_W'(req_amount);
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    // The value word is cut or zero-extended to the stored data width.
    generate
        if (DATA_WIDTH >= cal_pkg::VALUE_W) begin : g_wide_in
            assign append_data = DATA_WIDTH'(req_value);
        end else begin : g_narrow_in
            assign append_data = req_value[DATA_WIDTH-1:0];
        end
    endgenerate

    // Row of cells; on a remove, each cell from the removed index upward takes its upper neighbor's entry.
    generate
        for (genvar c = 0; c < DEPTH; c++) begin : g_cell
            logic [DATA_WIDTH-1:0] upper;
            if (c == DEPTH - 1) begin : g_top
                assign upper = '0;
            end else begin : g_mid
                assign upper = cell_data[c+1];
            end
            cal_cell #(
                .CELL_IDX   (c),
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .count       (count_reg),
                .append_data (append_data),
                .upper_data  (upper),
                .data        (cell_data[c])
            );
        end
    endgenerate

    // Read port: only the first sixteen cells are reachable by a 4-bit index.
    always_comb begin
        read_data = '0;
        for (int j = 0; j < RD_N; j++) begin
            if (req_index == cal_pkg::INDEX_W'(j)) begin
                read_data = cal_pkg::VALUE_W'(cell_data[j]);
            end
        end
        if (req_op != cal_pkg::OP_READ || !index_ok) begin
            read_data = '0;
        end
    end

    assign next_ext = CMP_W'(count_next);

    always_comb begin
        m_data_next = '0;
        m_data_next[31:0]  = read_data;
        m_data_next[36:32] = next_ext[cal_pkg::LEN_W-1:0];
        m_data_next[68:37] = cost_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= cal_pkg::CAP_RESET;
            count_reg    <= '0;
            cost_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
            if (req_fire) begin
                count_reg   <= count_next;
                cost_reg    <= cost_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (req_fire) begin
            m_data_reg <= m_data_next;
            m_err_reg  <= err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

endmodule

>>> test/compacting_array_list_checker.sv
// Checker for the compacting array list: tracks requests, predicts results and compares them.
module compacting_array_list_checker
    import cal_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   m_tuser,
    output int unsigned            fail_count,
    output int unsigned            outstanding,
    output logic [LEN_W-1:0]       list_length
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]   length;
        logic [COST_W-1:0]  cost_count;
        logic               error;
    } list_result_t;

    logic [VALUE_W-1:0] slots [DEPTH];
    logic [LEN_W-1:0]   used;
    logic [COST_W-1:0]  cost_total;
    logic [CAP_W-1:0]   capacity;
    list_result_t       expected_results [$];

    // Applies one request to the shadow list and returns the result it should produce.
    function automatic list_result_t apply_list_request(op_t op, logic [VALUE_W-1:0] value,
                                                         logic [INDEX_W-1:0] index,
                                                         logic [AMOUNT_W-1:0] amount);
        list_result_t res;
        int unsigned  fill_limit;
        int unsigned  n;
        int unsigned  idx;
        res = '0;
        fill_limit = (capacity > DEPTH) ? DEPTH : capacity;
        n = used;
        idx = index;
        case (op)
            OP_APPEND: begin
                if (n >= fill_limit) begin
                    res.error = 1'b1;
                end else begin
                    slots[n] = value;
                    used = used + 1'b1;
                    cost_total = cost_total + 1;
                end
            end
            OP_REMOVE: begin
                if (idx >= n) begin
                    res.error = 1'b1;
                end else begin
                    for (int k = idx; k + 1 < n; k++) slots[k] = slots[k+1];
                    slots[n-1] = '0;
                    // The last entry costs one; an earlier one costs length minus two minus index.
                    cost_total = cost_total + ((idx + 1 == n) ? 32'd1 : 32'(n - 2 - idx));
                    used = used - 1'b1;
                end
            end
            OP_READ: begin
                if (idx >= n) res.error = 1'b1;
                else res.read_value = slots[idx];
            end
            default: begin
                cost_total = cost_total + amount;
            end
        endcase
        res.length = used;
        res.cost_count = cost_total;
        return res;
    endfunction

    initial begin
        fail_count = 0;
        outstanding = 0;
        list_length = '0;
    end

    always @(posedge aclk) begin
        list_result_t exp_res;
        list_result_t got_res;
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) slots[k] = '0;
            used = '0;
            cost_total = '0;
            capacity = CAP_RESET;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) capacity = cfg_wr_data;
            // Results are matched before new requests are added, since a result always
            // belongs to a request accepted at an earlier edge.
            if (m_tvalid && m_tready) begin
                got_res.read_value = m_tdata[VALUE_W-1:0];
                got_res.length = m_tdata[VALUE_W +: LEN_W];
                got_res.cost_count = m_tdata[VALUE_W+LEN_W +: COST_W];
                got_res.error = m_tuser;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no request waiting: value=%h length=%0d cost=%h error=%0b",
                             $time, got_res.read_value, got_res.length, got_res.cost_count,
                             got_res.error);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got_res !== exp_res) begin
                        $display("%0t: mismatch: expected value=%h length=%0d cost=%h error=%0b",
                                 $time, exp_res.read_value, exp_res.length, exp_res.cost_count,
                                 exp_res.error);
                        $display("%0t:            actual value=%h length=%0d cost=%h error=%0b",
                                 $time, got_res.read_value, got_res.length, got_res.cost_count,
                                 got_res.error);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_list_request(op_t'(s_tuser),
                                                              s_tdata[VALUE_W-1:0],
                                                              s_tdata[VALUE_W +: INDEX_W],
                                                              s_tdata[VALUE_W+INDEX_W +: AMOUNT_W]));
            end
        end
        outstanding = expected_results.size();
        list_length = used;
    end

endmodule

>>> test/compacting_array_list_unit_tb.sv
// Testbench top for the compacting array list: clock, reset, request and result traffic, verdict.
module compacting_array_list_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cal_pkg::*;

    // The slowest correct run stays well below this: the burst runs near full rate
    // and each random request waits at most one randomly drawn gap on each side.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Length of the single long result stall that fills the block and blocks requests.
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned RANDOM_PER_PHASE = 100;
    // Short run of maximum additions sent back to back with no idling on either side.
    localparam int unsigned BURST_REQUESTS = 32;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CAP_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]        s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    int unsigned            fail_count;
    int unsigned            outstanding;
    logic [LEN_W-1:0]       list_length;
    int unsigned            cycle_count = 0;

    // Idling switches for the two sides, and the request for one long result stall.
    logic                   tx_idle;
    logic                   rx_idle;
    logic                   long_hold_req;

    // Capacity settings, one per random phase. The sequence lowers the capacity below the
    // length the list holds, goes to zero, and goes above the built depth.
    logic [CAP_W-1:0] phase_capacity [8] = '{5'd31, 5'd4, 5'd0, 5'd1, 5'd17, 5'd9, 5'd16, 5'd2};

    compacting_array_list_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    compacting_array_list_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .list_length (list_length)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: a hung handshake must not keep the run going forever.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one request. Inputs only change at the falling edge, and the handshake is
    // sampled at the rising edge. Valid is lowered only when a gap is drawn, so a request
    // that follows directly keeps valid high without a drop inside the same time step.
    task automatic send_request(input op_t op, input logic [VALUE_W-1:0] value,
                                input logic [INDEX_W-1:0] index,
                                input logic [AMOUNT_W-1:0] amount);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{(S_TDATA_W - VALUE_W - INDEX_W - AMOUNT_W){1'b0}}, amount, index, value};
        s_tuser = op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Builds one random request. Most removes and reads aim at an index the list holds,
    // using the length the checker tracks, so that the shifting paths get exercised;
    // the rest pick any index and mostly hit the out-of-range refusal.
    task automatic send_random_request();
        int unsigned        pick;
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic [AMOUNT_W-1:0] amount;
        pick = $urandom_range(0, 99);
        if (pick < 38) op = OP_APPEND;
        else if (pick < 63) op = OP_REMOVE;
        else if (pick < 88) op = OP_READ;
        else op = OP_ADD_COST;
        pick = $urandom_range(0, 9);
        value = (pick == 0) ? '1 : (pick == 1) ? '0 : VALUE_W'($urandom());
        pick = $urandom_range(0, 9);
        amount = (pick == 0) ? '1 : (pick == 1) ? '0 : AMOUNT_W'($urandom());
        if (list_length != 0 && $urandom_range(0, 9) < 8)
            index = INDEX_W'($urandom_range(0, list_length - 1));
        else
            index = INDEX_W'($urandom_range(0, INDEX_SPAN - 1));
        send_request(op, value, index, amount);
    endtask

    // Writes the capacity once the block is idle: with valid held low, every expected result
    // has come back before the write.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = cap;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Result side: each result waits a drawn number of cycles before ready goes high.
    // One long stall is taken on request, counted here in its own loop.
    initial begin
        int unsigned gap;
        logic        hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        repeat (10) @(negedge aclk);
        forever begin
            if (long_hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = 1'b1;
            end
            gap = rx_idle ? $urandom_range(0, 14) : 0;
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_APPEND;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        long_hold_req = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at full capacity. The list is filled to the built depth with the
        // extreme data words among the entries, then an append to the full list must be
        // refused. Reads hit the first and the highest index, the first entry is removed
        // (the costliest shift), a read past the new length fails, the last entry is
        // removed, a remove past the length fails, and the cost counter takes the largest
        // and the smallest addition.
        set_capacity(CAP_RESET);
        for (int k = 0; k < 16; k++) begin
            send_request(OP_APPEND, (k == 0) ? '1 : (k == 1) ? '0 : VALUE_W'($urandom()),
                         '0, '0);
        end
        send_request(OP_APPEND, 32'hA5A5_5A5A, '0, '0);
        send_request(OP_READ, '0, 4'd15, '0);
        send_request(OP_READ, '0, 4'd0, '0);
        send_request(OP_REMOVE, '0, 4'd0, '0);
        send_request(OP_READ, '0, 4'd15, '0);
        send_request(OP_REMOVE, '0, 4'd14, '0);
        send_request(OP_REMOVE, '0, 4'd15, '0);
        send_request(OP_ADD_COST, '0, '0, '1);
        send_request(OP_ADD_COST, '0, '0, '0);
        send_request(OP_READ, '0, 4'd3, '0);

        // Back-to-back maximum additions at full rate.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int k = 0; k < BURST_REQUESTS; k++) send_request(OP_ADD_COST, '0, '0, '1);

        // Random phases, each under its own capacity. Phase one floods requests while
        // the result side takes its long stall; phase five runs with no idling at all;
        // phase three keeps the result side always ready.
        for (int p = 0; p < 8; p++) begin
            set_capacity(phase_capacity[p]);
            tx_idle = !(p == 1 || p == 5);
            rx_idle = !(p == 3 || p == 5);
            if (p == 1) long_hold_req = 1'b1;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) send_random_request();
        end

        // Drain: wait for every expected result, then keep the checker running to catch stray ones.
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cal_pkg.sv
rtl/core/cal_cell.sv
rtl/core/compacting_array_list_unit.sv
test/compacting_array_list_checker.sv
test/compacting_array_list_unit_tb.sv
